@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the top level and slot flag rtl files of the slot pool allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// concurrent check, disabled while reset is asserted
`define TSP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define TSP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSP_ASSERT(name, clk, rst_n, prop, msg)
`define TSP_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

@@ hw/rtl/tsp_pkg.sv @@
// types, constants and helper functions of the slot pool allocator
package tsp_pkg;

  localparam int POOL_SLOTS       = 128;
  localparam int MAX_LEVEL        = 4;
  localparam int TILES_PER_SIDE   = 4;

  localparam int PATCHES_PER_TILE = ((1 << (2 * (MAX_LEVEL + 1))) - 1) / 3;
  localparam int MAP_DEPTH        = PATCHES_PER_TILE * TILES_PER_SIDE * TILES_PER_SIDE;

  localparam int SLOT_W  = $clog2(POOL_SLOTS);
  localparam int ENTRY_W = $clog2(POOL_SLOTS + 1);
  localparam int USED_W  = $clog2(POOL_SLOTS + 1);
  localparam int MAP_AW  = $clog2(MAP_DEPTH);
  localparam int CNT_W   = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_TOUCH   = 2'd1,
    ACT_FRAME   = 2'd2,
    ACT_IGNORE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE,
    ST_EVICT
  } state_e;

  // update request from the controller to the slot flag vectors
  typedef struct packed {
    logic              mark;
    logic              alloc;
    logic              frame_end;
    logic [SLOT_W-1:0] slot;
  } flag_cmd_t;

  // slot flag status seen by the controller
  typedef struct packed {
    logic              any_free;
    logic [SLOT_W-1:0] free_slot;
    logic              free_owned;
    logic [USED_W-1:0] used_cnt;
  } flag_stat_t;

  // first map index of a quadtree level inside one tile
  function automatic int level_base(input logic [2:0] lvl);
    int sum;
    sum = 0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(lvl)) begin
        sum += 1 << (2 * i);
      end
    end
    return sum;
  endfunction

endpackage

@@ hw/rtl/tile_slot_pool_allocator.sv @@
// top level of the terrain patch slot pool allocator
// After reset the block sweeps the map ram to empty, one entry a cycle, over
// all 5456 entries (the map depth); stall stays high during the sweep. Each
// item is then taken in the idle state, which reads the map ram, and resolved
// and written back in the resolve step, which loads its result into the
// output register. When a new slot is handed out whose previous owner's map
// entry must be erased, the input stays stalled for an extra evict step, since
// the map ram has a single write port; the result comes at the same time as
// otherwise. One item is in flight at a time. The result sits in an output
// register, so the result of an item can wait while the next one is taken in;
// a result that is still stalled holds the following item in its resolve step.
`include "assert_macros.svh"

module tile_slot_pool_allocator import tsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [1:0]         tile_x_i,
  input  logic [1:0]         tile_y_i,
  input  logic [2:0]         level_i,
  input  logic [3:0]         patch_x_i,
  input  logic [3:0]         patch_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [7:0]  slot_o,
  output logic               hit_o,
  output logic               stream_issue_o,
  output logic [12:0]        map_index_o,
  output logic [7:0]         used_count_o,
  output logic [15:0]        streamed_count_o,
  output logic [15:0]        idle_frames_o
);

  state_e             state_q, state_d;
  logic [MAP_AW-1:0]  clr_q;
  logic               accept;

  // index of the patch and range check
  logic [MAP_AW:0]    idx_full;
  logic               in_range;

  // transaction held for the resolve step
  action_e            act_q;
  logic               ok_q;
  logic [MAP_AW-1:0]  idx_q;
  logic               any_free_q;
  logic [SLOT_W-1:0]  free_slot_q;
  logic               free_owned_q;

  flag_cmd_t          cmd;
  flag_stat_t         stat;

  logic [ENTRY_W-1:0] map_rdata;
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [ENTRY_W-1:0] map_wdata;
  logic [MAP_AW-1:0]  own_rdata;
  logic               own_we;

  logic [CNT_W-1:0]   strm_q;
  logic [CNT_W-1:0]   idle_q;

  logic               out_valid_q;
  logic signed [7:0]  slot_q;
  logic               hit_q;
  logic               stream_q;
  logic [12:0]        idx_out_q;
  logic [7:0]         used_out_q;
  logic [15:0]        strm_out_q;
  logic [15:0]        idle_out_q;

  logic               out_free;
  logic               resolve_go;
  logic               is_frame;
  logic               is_lookup;
  logic               is_hit;
  logic               do_alloc;
  logic [7:0]         used_sat;

  assign accept = in_valid_i && !in_stall_o;

  // linear map index over all tiles
  always_comb begin
    idx_full = (MAP_AW + 1)'(PATCHES_PER_TILE
               * (int'(tile_y_i) * TILES_PER_SIDE + int'(tile_x_i))
               + level_base(level_i) + int'(patch_x_i)
               + (int'(patch_y_i) << level_i));
    in_range = (int'(level_i) <= MAX_LEVEL)
            && (int'(tile_x_i) < TILES_PER_SIDE)
            && (int'(tile_y_i) < TILES_PER_SIDE)
            && ((int'(patch_x_i) >> level_i) == 0)
            && ((int'(patch_y_i) >> level_i) == 0)
            && (int'(idx_full) < MAP_DEPTH);
  end

  // slot flag vectors
  tsp_slot_flags u_flags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // map ram: entry is slot plus one, zero when empty
  tsp_ram #(
    .DEPTH (MAP_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_map_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (idx_full[MAP_AW-1:0]),
    .rd_data_o (map_rdata),
    .wr_en_i   (map_we),
    .wr_addr_i (map_waddr),
    .wr_data_i (map_wdata)
  );

  // owner ram: map index held by each slot
  tsp_ram #(
    .DEPTH (POOL_SLOTS),
    .WIDTH (MAP_AW)
  ) u_owner_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (stat.free_slot),
    .rd_data_o (own_rdata),
    .wr_en_i   (own_we),
    .wr_addr_i (free_slot_q),
    .wr_data_i (idx_q)
  );

  // decode of the held transaction
  assign out_free   = !out_valid_q || !out_stall_i;
  assign resolve_go = (state_q == ST_RESOLVE) && out_free;
  assign is_frame   = (act_q == ACT_FRAME);
  assign is_lookup  = ok_q && ((act_q == ACT_REQUEST) || (act_q == ACT_TOUCH));
  assign is_hit     = is_lookup && (map_rdata != '0);
  assign do_alloc   = is_lookup && !is_hit && (act_q == ACT_REQUEST) && any_free_q;
  assign used_sat   = (32'(stat.used_cnt) > 32'd255) ? 8'hFF : 8'(stat.used_cnt);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, map and owner writes, flag commands
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd        = '0;
    map_we     = 1'b0;
    map_waddr  = idx_q;
    map_wdata  = '0;
    own_we     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        if (clr_q == MAP_AW'(MAP_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          state_d       = ST_IDLE;
          cmd.frame_end = is_frame;
          cmd.mark      = is_hit;
          cmd.alloc     = do_alloc;
          cmd.slot      = is_hit ? SLOT_W'(map_rdata - ENTRY_W'(1)) : free_slot_q;
          if (do_alloc) begin
            map_we    = 1'b1;
            map_waddr = idx_q;
            map_wdata = ENTRY_W'(free_slot_q) + ENTRY_W'(1);
            own_we    = 1'b1;
            if (free_owned_q) begin
              state_d = ST_EVICT;
            end
          end
        end
      end
      ST_EVICT: begin
        map_we    = 1'b1;
        map_waddr = own_rdata;
        map_wdata = '0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == ST_CLEAR) begin
      clr_q <= clr_q + MAP_AW'(1);
    end
  end

  // capture of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q        <= action_e'(action_i);
      ok_q         <= in_range;
      idx_q        <= idx_full[MAP_AW-1:0];
      any_free_q   <= stat.any_free;
      free_slot_q  <= stat.free_slot;
      free_owned_q <= stat.free_owned;
    end
  end

  // streamed and idle frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strm_q <= '0;
      idle_q <= '0;
    end else if (resolve_go) begin
      if (is_frame) begin
        if (strm_q != '0) begin
          strm_q <= '0;
          idle_q <= '0;
        end else if (idle_q != CNT_MAX) begin
          idle_q <= idle_q + CNT_W'(1);
        end
      end else if (do_alloc && (strm_q != CNT_MAX)) begin
        strm_q <= strm_q + CNT_W'(1);
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resolve_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (resolve_go) begin
      if (is_hit) begin
        slot_q <= 8'(map_rdata - ENTRY_W'(1));
      end else if (do_alloc) begin
        slot_q <= 8'(free_slot_q);
      end else begin
        slot_q <= -8'sd1;
      end
      hit_q      <= is_hit;
      stream_q   <= do_alloc;
      idx_out_q  <= is_lookup ? 13'(idx_q) : '0;
      used_out_q <= is_frame ? used_sat : '0;
      strm_out_q <= is_frame ? strm_q : '0;
      idle_out_q <= is_frame ? idle_q : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign slot_o           = slot_q;
  assign hit_o            = hit_q;
  assign stream_issue_o   = stream_q;
  assign map_index_o      = idx_out_q;
  assign used_count_o     = used_out_q;
  assign streamed_count_o = strm_out_q;
  assign idle_frames_o    = idle_out_q;

  `TSP_ASSERT_ALWAYS(a_clear_stalls, clk_i, (state_q == ST_CLEAR) |-> in_stall_o, "input taken during map clearing")
  `TSP_ASSERT(a_evict_after_resolve, clk_i, rst_ni, (state_q == ST_EVICT) |-> $past(state_q == ST_RESOLVE), "eviction without allocation")
  `TSP_ASSERT(a_map_entry_bound, clk_i, rst_ni, map_we |-> (map_wdata <= ENTRY_W'(POOL_SLOTS)), "map entry beyond pool")
  `TSP_ASSERT(a_stream_has_slot, clk_i, rst_ni, (out_valid_q && stream_q) |-> (!hit_q && (slot_q >= 0)), "stream command without slot")

endmodule

@@ hw/rtl/tsp_ram.sv @@
// single write port ram with one registered read port
module tsp_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/tsp_slot_flags.sv @@
// per-slot free, used and owned flags with lowest free slot search
`include "assert_macros.svh"

module tsp_slot_flags import tsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  flag_cmd_t  cmd_i,
  output flag_stat_t stat_o
);

  logic [POOL_SLOTS-1:0] free_q;
  logic [POOL_SLOTS-1:0] used_q;
  logic [POOL_SLOTS-1:0] owned_q;
  logic [USED_W-1:0]     used_cnt_q;

  logic [SLOT_W-1:0]     first_free;

  // lowest free slot
  always_comb begin
    first_free = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        first_free = SLOT_W'(i);
      end
    end
  end

  assign stat_o.any_free   = |free_q;
  assign stat_o.free_slot  = first_free;
  assign stat_o.free_owned = owned_q[first_free];
  assign stat_o.used_cnt   = used_cnt_q;

  // flag update; the used count follows the used vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q     <= '1;
      used_q     <= '0;
      owned_q    <= '0;
      used_cnt_q <= '0;
    end else if (cmd_i.frame_end) begin
      free_q     <= ~used_q;
      used_q     <= '0;
      used_cnt_q <= '0;
    end else begin
      if (cmd_i.mark || cmd_i.alloc) begin
        used_q[cmd_i.slot] <= 1'b1;
        if (!used_q[cmd_i.slot]) begin
          used_cnt_q <= used_cnt_q + USED_W'(1);
        end
      end
      if (cmd_i.alloc) begin
        free_q[cmd_i.slot]  <= 1'b0;
        owned_q[cmd_i.slot] <= 1'b1;
      end
    end
  end

  `TSP_ASSERT(a_used_cnt_bound, clk_i, rst_ni, used_cnt_q <= USED_W'(POOL_SLOTS), "used count above pool size")
  `TSP_ASSERT(a_frame_clears, clk_i, rst_ni, cmd_i.frame_end |=> used_cnt_q == '0, "used count not cleared at frame end")
  `TSP_ASSERT(a_alloc_free, clk_i, rst_ni, cmd_i.alloc |-> free_q[cmd_i.slot], "allocation of a slot that is not free")
  `TSP_ASSERT(a_one_update, clk_i, rst_ni, !(cmd_i.mark && cmd_i.alloc), "hit and allocation in one transaction")

endmodule

@@ dv/tb_tile_slot_pool_allocator.sv @@
// self-checking testbench of the terrain patch slot pool allocator
module tb_tile_slot_pool_allocator;
  import tsp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int WS_SIZE      = 48;
  localparam logic signed [7:0] NO_SLOT = -8'sd1;

  // one patch address as carried by a command transaction
  typedef struct packed {
    logic [1:0] tx;
    logic [1:0] ty;
    logic [2:0] lvl;
    logic [3:0] px;
    logic [3:0] py;
  } patch_addr_t;

  // one result transaction, fields in port order
  typedef struct packed {
    logic signed [7:0] slot;
    logic              hit;
    logic              stream_issue;
    logic [12:0]       map_index;
    logic [7:0]        used_count;
    logic [15:0]       streamed_count;
    logic [15:0]       idle_frames;
  } patch_result_t;

  // shadow of the slot cache and the queue of results it predicts
  class patch_cache_scoreboard;
    bit [7:0]      map_entry [MAP_DEPTH];  // slot plus one, zero when empty
    bit            is_free   [POOL_SLOTS];
    bit            has_owner [POOL_SLOTS];
    int            owner_idx [POOL_SLOTS];
    bit            is_used   [POOL_SLOTS];
    int            streamed_cnt;
    int            idle_cnt;
    int            errors;
    patch_result_t expected_q [$];

    function new();
      foreach (map_entry[i]) map_entry[i] = '0;
      foreach (is_free[i]) begin
        is_free[i]   = 1'b1;
        has_owner[i] = 1'b0;
        owner_idx[i] = 0;
        is_used[i]   = 1'b0;
      end
      streamed_cnt = 0;
      idle_cnt     = 0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // predict the result of an accepted command transaction
    function void note_transaction(action_e act, patch_addr_t a);
      patch_result_t r;
      int idx;
      int used;
      int pick;
      r      = '0;
      r.slot = NO_SLOT;
      if (act == ACT_FRAME) begin
        // slots left untouched this frame go back to the free pool
        used = 0;
        for (int s = 0; s < POOL_SLOTS; s++) begin
          if (is_used[s]) used++;
          is_free[s] = !is_used[s];
          is_used[s] = 1'b0;
        end
        r.used_count     = (used > 255) ? 8'd255 : 8'(used);
        r.streamed_count = 16'(streamed_cnt);
        r.idle_frames    = 16'(idle_cnt);
        if (streamed_cnt > 0) begin
          streamed_cnt = 0;
          idle_cnt     = 0;
        end else if (idle_cnt < int'(CNT_MAX)) begin
          idle_cnt++;
        end
      end else if (act != ACT_IGNORE && a.lvl <= MAX_LEVEL &&
                   a.tx < TILES_PER_SIDE && a.ty < TILES_PER_SIDE &&
                   a.px < (1 << a.lvl) && a.py < (1 << a.lvl)) begin
        // levels below this one hold (4^lvl - 1) / 3 patches
        idx = PATCHES_PER_TILE * (a.tx + a.ty * TILES_PER_SIDE) +
              ((1 << (2 * a.lvl)) - 1) / 3 + a.px + a.py * (1 << a.lvl);
        r.map_index = 13'(idx);
        if (map_entry[idx] != 0) begin
          is_used[map_entry[idx] - 1] = 1'b1;
          r.slot = 8'(map_entry[idx] - 1);
          r.hit  = 1'b1;
        end else if (act == ACT_REQUEST) begin
          // lowest free slot wins, its old mapping is dropped
          pick = -1;
          for (int s = POOL_SLOTS - 1; s >= 0; s--) begin
            if (is_free[s]) pick = s;
          end
          if (pick >= 0) begin
            if (has_owner[pick]) map_entry[owner_idx[pick]] = '0;
            is_free[pick]   = 1'b0;
            has_owner[pick] = 1'b1;
            owner_idx[pick] = idx;
            is_used[pick]   = 1'b1;
            map_entry[idx]  = 8'(pick + 1);
            if (streamed_cnt < int'(CNT_MAX)) streamed_cnt++;
            r.slot         = 8'(pick);
            r.stream_issue = 1'b1;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // compare a result transaction with the oldest prediction
    task check_result(patch_result_t got);
      patch_result_t want;
      if (expected_q.size() == 0) begin
        report("result with no transaction pending");
      end else begin
        want = expected_q.pop_front();
        compare_field("slot", $signed(got.slot), $signed(want.slot));
        compare_field("hit", got.hit, want.hit);
        compare_field("stream_issue", got.stream_issue, want.stream_issue);
        compare_field("map_index", got.map_index, want.map_index);
        compare_field("used_count", got.used_count, want.used_count);
        compare_field("streamed_count", got.streamed_count, want.streamed_count);
        compare_field("idle_frames", got.idle_frames, want.idle_frames);
      end
    endtask
  endclass

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  action_e       action    = ACT_REQUEST;
  patch_addr_t   cmd_addr  = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  patch_result_t seen_result;
  int            cycle_cnt  = 0;
  int            burst_left = 0;
  bit            steady     = 1'b0;

  patch_cache_scoreboard sb = new();

  tile_slot_pool_allocator u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .tile_x_i         (cmd_addr.tx),
    .tile_y_i         (cmd_addr.ty),
    .level_i          (cmd_addr.lvl),
    .patch_x_i        (cmd_addr.px),
    .patch_y_i        (cmd_addr.py),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .slot_o           (seen_result.slot),
    .hit_o            (seen_result.hit),
    .stream_issue_o   (seen_result.stream_issue),
    .map_index_o      (seen_result.map_index),
    .used_count_o     (seen_result.used_count),
    .streamed_count_o (seen_result.streamed_count),
    .idle_frames_o    (seen_result.idle_frames)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL tile_slot_pool_allocator");
      $finish;
    end
  end

  // receiver stall pattern, changes character with bits 9 and 8 of the cycle count
  always @(posedge clk) begin
    case (cycle_cnt[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= cycle_cnt[2];
    endcase
  end

  // watch both channels for completed transactions
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_transaction(action, cmd_addr);
    if (rst_n && out_valid && !out_stall) sb.check_result(seen_result);
  end

  function automatic patch_addr_t patch_at(int tx, int ty, int lvl, int px, int py);
    patch_addr_t a;
    a.tx  = 2'(tx);
    a.ty  = 2'(ty);
    a.lvl = 3'(lvl);
    a.px  = 4'(px);
    a.py  = 4'(py);
    return a;
  endfunction

  // any patch that exists in the quadtree
  function automatic patch_addr_t random_patch();
    patch_addr_t a;
    a.tx  = 2'($urandom_range(0, TILES_PER_SIDE - 1));
    a.ty  = 2'($urandom_range(0, TILES_PER_SIDE - 1));
    a.lvl = 3'($urandom_range(0, MAX_LEVEL));
    a.px  = 4'($urandom_range(0, (1 << a.lvl) - 1));
    a.py  = 4'($urandom_range(0, (1 << a.lvl) - 1));
    return a;
  endfunction

  // drive one command transaction, with bursts and gaps between them
  task automatic send_cmd(action_e act, patch_addr_t a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    cmd_addr <= a;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // stimulus
  initial begin
    patch_addr_t ws [WS_SIZE];
    patch_addr_t a;
    patch_addr_t tile;
    int pick;
    int offs;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: hits, misses, bad addresses, frame ends, slot reuse
    send_cmd(ACT_REQUEST, patch_at(0, 0, 0, 0, 0));     // root miss
    send_cmd(ACT_REQUEST, patch_at(0, 0, 0, 0, 0));     // request hit
    send_cmd(ACT_TOUCH,   patch_at(0, 0, 0, 0, 0));     // touch hit
    send_cmd(ACT_TOUCH,   patch_at(3, 3, 4, 15, 15));   // touch miss, last index
    send_cmd(ACT_REQUEST, patch_at(3, 3, 4, 15, 15));
    send_cmd(ACT_REQUEST, patch_at(1, 2, 5, 0, 0));     // level beyond max
    send_cmd(ACT_TOUCH,   patch_at(2, 1, 7, 15, 15));
    send_cmd(ACT_REQUEST, patch_at(0, 3, 2, 4, 0));     // column outside level
    send_cmd(ACT_REQUEST, patch_at(3, 0, 1, 0, 2));     // row outside level
    send_cmd(ACT_IGNORE,  patch_at(3, 3, 7, 15, 15));
    send_cmd(ACT_IGNORE,  patch_at(0, 0, 0, 0, 0));
    send_cmd(ACT_FRAME,   patch_at(3, 3, 7, 15, 15));
    send_cmd(ACT_FRAME,   patch_at(0, 0, 0, 0, 0));     // idle frames start
    send_cmd(ACT_FRAME,   patch_at(1, 2, 3, 4, 5));
    send_cmd(ACT_TOUCH,   patch_at(0, 0, 0, 0, 0));     // hit on a freed slot
    send_cmd(ACT_REQUEST, patch_at(1, 2, 3, 5, 6));     // takes it back, evicts root
    send_cmd(ACT_TOUCH,   patch_at(0, 0, 0, 0, 0));     // root now gone
    send_cmd(ACT_REQUEST, patch_at(2, 1, 4, 8, 3));
    send_cmd(ACT_FRAME,   patch_at(0, 0, 0, 0, 0));
    wait_drained();

    // random traffic over a small working set so hits and reuse are common
    for (int k = 0; k < WS_SIZE; k++) ws[k] = random_patch();
    for (int n = 0; n < 180; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_cmd(ACT_REQUEST, ws[$urandom_range(0, WS_SIZE - 1)]);
      else if (pick < 75) send_cmd(ACT_TOUCH, ws[$urandom_range(0, WS_SIZE - 1)]);
      else if (pick < 82) send_cmd(ACT_FRAME, patch_addr_t'($urandom));
      else if (pick < 92) send_cmd(action_e'($urandom_range(0, 1)), random_patch());
      else send_cmd(action_e'($urandom_range(0, 3)), patch_addr_t'($urandom));
    end
    wait_drained();

    // fill the pool with distinct patches of one tile until it runs dry
    send_cmd(ACT_FRAME, random_patch());
    send_cmd(ACT_FRAME, random_patch());
    tile = random_patch();
    offs = $urandom_range(0, 255);
    for (int n = 0; n < 140; n++) begin
      steady = (n < 70);
      a      = tile;
      a.lvl  = 3'(MAX_LEVEL);
      a.px   = 4'((offs + n) % 16);
      a.py   = 4'(((offs + n) / 16) % 16);
      send_cmd(ACT_REQUEST, a);
      if ($urandom_range(0, 9) == 0) send_cmd(ACT_TOUCH, a);
    end
    steady = 1'b0;
    send_cmd(ACT_FRAME, random_patch());

    // pool starts out fully held, then mixed traffic and noise
    for (int k = 0; k < WS_SIZE; k++) ws[k] = random_patch();
    for (int n = 0; n < 80; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) send_cmd(ACT_REQUEST, ws[$urandom_range(0, WS_SIZE - 1)]);
      else if (pick < 65) send_cmd(ACT_TOUCH, ws[$urandom_range(0, WS_SIZE - 1)]);
      else if (pick < 75) send_cmd(ACT_FRAME, patch_addr_t'($urandom));
      else send_cmd(action_e'($urandom_range(0, 3)), patch_addr_t'($urandom));
    end

    // wind down
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASS tile_slot_pool_allocator");
    end else begin
      $display("FAIL tile_slot_pool_allocator");
    end
    $finish;
  end

endmodule
